/* sv/hue_step_palette_hsv_to_rgb_defines.svh */
// ----------------------------------------------------------------------------
// Hue-step palette assertion macros
// Concurrent check helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUE_STEP_PALETTE_HSV_TO_RGB_DEFINES_SVH
`define HUE_STEP_PALETTE_HSV_TO_RGB_DEFINES_SVH

`ifndef SYNTHESIS
`define HSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hue step palette check failed");
`define HSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hue step palette check failed");
`else
`define HSP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HSP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/hspal_pkg.sv */
// ----------------------------------------------------------------------------
// hspal_pkg
// Widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hspal_pkg;

    localparam int KNOB_W   = 7;
    localparam int COUNT_W  = 10;
    localparam int IDX_W    = 17;
    localparam int SUM_W    = 24;
    localparam int FRAC_W   = 12;
    localparam int Q_W      = 15;
    localparam int CH_W     = 8;
    localparam int STEP_W   = 4;
    localparam int IN_W     = 4 * KNOB_W;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 4 * CH_W;

    localparam logic [STEP_W-1:0] D1_LAST = 4'd6;
    localparam logic [STEP_W-1:0] D2_LAST = 4'd14;

    localparam logic [KNOB_W-1:0] KNOB_MAX = 7'd127;
    localparam logic [14:0]       DIV_K    = 15'd127;
    localparam logic [14:0]       RECIP    = 15'd16513;
    localparam logic [FRAC_W:0]   RAMP_ONE = 13'd4096;
    localparam logic [19:0]       NUM_ONE  = 20'd520192;
    localparam logic [CH_W-1:0]   CH_FULL  = 8'hFF;

    localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;
    localparam logic [2:0] SEC_BLUE_RED   = 3'd4;

    typedef struct packed {
        logic capture;
        logic mul;
        logic d1_load;
        logic d2_load;
        logic div_step;
        logic mix1;
        logic mix2;
        logic mix3;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

endpackage

/* sv/hspal_ctrl.sv */
// ----------------------------------------------------------------------------
// hspal_ctrl
// Request sequencer: accept, multiply, divide, mix, hand off to the output register.
// ----------------------------------------------------------------------------
module hspal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  hspal_pkg::t_sts  i_sts,
    output hspal_pkg::t_cmd  o_cmd
);
    import hspal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_D1LD,
        S_D1,
        S_D2LD,
        S_D2,
        S_MX1,
        S_MX2,
        S_MX3,
        S_MX4
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept    = i_in_valid & r_in_ready;
    assign w_out_free  = ~r_out_valid | i_out_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_accept;
        case (r_state)
            S_MUL:   o_cmd.mul      = 1'b1;
            S_D1LD:  o_cmd.d1_load  = 1'b1;
            S_D1:    o_cmd.div_step = 1'b1;
            S_D2LD:  o_cmd.d2_load  = 1'b1;
            S_D2:    o_cmd.div_step = 1'b1;
            S_MX1:   o_cmd.mix1     = 1'b1;
            S_MX2:   o_cmd.mix2     = 1'b1;
            S_MX3:   o_cmd.mix3     = 1'b1;
            S_MX4:   o_cmd.out_load = w_out_free;
            default: o_cmd.capture  = w_accept;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state    <= S_MUL;
                        r_in_ready <= 1'b0;
                    end
                end
                S_MUL:  r_state <= S_D1LD;
                S_D1LD: r_state <= S_D1;
                S_D1: begin
                    if (i_sts.div_last) begin
                        r_state <= S_D2LD;
                    end
                end
                S_D2LD: r_state <= S_D2;
                S_D2: begin
                    if (i_sts.div_last) begin
                        r_state <= S_MX1;
                    end
                end
                S_MX1:  r_state <= S_MX2;
                S_MX2:  r_state <= S_MX3;
                S_MX3:  r_state <= S_MX4;
                S_MX4: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* sv/hspal_dp.sv */
// ----------------------------------------------------------------------------
// hspal_dp
// Datapath: angle products, shared restoring divider, channel mixing.
// ----------------------------------------------------------------------------
module hspal_dp #(
    parameter int MAX_COUNT = 1023
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hspal_pkg::t_cmd                      i_cmd,
    output hspal_pkg::t_sts                      o_sts,
    input  logic [hspal_pkg::IN_W-1:0]           i_in_data,
    input  logic                                 i_cfg_write,
    input  logic [hspal_pkg::COUNT_W-1:0]        i_cfg_data,
    output logic [hspal_pkg::TDATA_OUT_W-1:0]    o_out_data
);
    import hspal_pkg::*;

    logic [COUNT_W-1:0]     r_count;
    logic [IDX_W-1:0]       r_idx;
    logic [KNOB_W-1:0]      r_hue, r_win, r_sat, r_int;
    logic [SUM_W-1:0]       r_sum;
    logic [IDX_W-1:0]       r_rem;
    logic [IDX_W-1:0]       r_div;
    logic [Q_W-1:0]         r_bits;
    logic [Q_W-1:0]         r_q;
    logic [STEP_W-1:0]      r_cnt;
    logic [19:0]            r_sr;
    logic [14:0]            r_vx, r_vz, r_va;
    logic [CH_W-1:0]        r_ex, r_ez, r_ea;
    logic [TDATA_OUT_W-1:0] r_out;

    logic [COUNT_W-1:0]     w_cfg_count;
    logic [IDX_W-1:0]       w_m;
    logic [IDX_W-1:0]       w_idx_inc;
    logic [16:0]            w_prod_hue;
    logic [SUM_W-1:0]       w_prod_idx;
    logic [IDX_W-1:0]       w_a;
    logic [19:0]            w_t;
    logic [IDX_W:0]         w_rr;
    logic                   w_ge;
    logic [FRAC_W:0]        w_ramp;
    logic [19:0]            w_sat_ramp;
    logic [19:0]            w_num;
    logic [27:0]            w_num255;
    logic [KNOB_W-1:0]      w_nsat;
    logic [14:0]            w_vz, w_va;
    logic [29:0]            w_px, w_pz, w_pa;
    logic [CH_W-1:0]        w_x, w_z, w_al;
    logic [CH_W-1:0]        w_red, w_green, w_blue;

    function automatic logic [CH_W-1:0] fix127(input logic [14:0] v, input logic [CH_W-1:0] e);
        logic [14:0] m;
        logic [14:0] r;
        logic [CH_W:0] e1;
        m  = {e, 7'b0} - {7'b0, e};
        r  = v - m;
        e1 = {1'b0, e} + 9'd1;
        fix127 = (r >= DIV_K) ? e1[CH_W-1:0] : e;
    endfunction

    always_comb begin
        w_cfg_count = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_cfg_count = COUNT_W'(1);
        end
        if (32'(i_cfg_data) > 32'(MAX_COUNT)) begin
            w_cfg_count = COUNT_W'(MAX_COUNT);
        end
    end

    assign w_m        = {r_count, 7'b0};
    assign w_idx_inc  = r_idx + IDX_W'(1);
    assign w_prod_hue = r_hue * r_count;
    assign w_prod_idx = r_idx * r_win;

    assign w_a = {r_rem[COUNT_W-1:0], r_sum[6:0]};
    assign w_t = {1'b0, w_a, 2'b0} + {2'b0, w_a, 1'b0};

    assign w_rr = {r_rem, r_bits[Q_W-1]};
    assign w_ge = w_rr >= {1'b0, r_div};

    assign w_ramp     = r_q[FRAC_W] ? (RAMP_ONE - {1'b0, r_q[FRAC_W-1:0]})
                                    : {1'b0, r_q[FRAC_W-1:0]};
    assign w_sat_ramp = r_sat * w_ramp;

    assign w_num    = NUM_ONE - {1'b0, r_sat, 12'b0} + r_sr;
    assign w_num255 = {w_num, 8'b0} - {8'b0, w_num};
    assign w_nsat   = KNOB_MAX - r_sat;
    assign w_vz     = {w_nsat, 8'b0} - {8'b0, w_nsat};
    assign w_va     = {r_int, 8'b0} - {8'b0, r_int};

    assign w_px = r_vx * RECIP;
    assign w_pz = r_vz * RECIP;
    assign w_pa = r_va * RECIP;

    assign w_x  = fix127(r_vx, r_ex);
    assign w_z  = fix127(r_vz, r_ez);
    assign w_al = fix127(r_va, r_ea);

    always_comb begin
        case (r_q[Q_W-1:FRAC_W])
            SEC_RED_GREEN: begin
                w_red = CH_FULL; w_green = w_x;     w_blue = w_z;
            end
            SEC_GREEN_RED: begin
                w_red = w_x;     w_green = CH_FULL; w_blue = w_z;
            end
            SEC_GREEN_BLUE: begin
                w_red = w_z;     w_green = CH_FULL; w_blue = w_x;
            end
            SEC_BLUE_GREEN: begin
                w_red = w_z;     w_green = w_x;     w_blue = CH_FULL;
            end
            SEC_BLUE_RED: begin
                w_red = w_x;     w_green = w_z;     w_blue = CH_FULL;
            end
            default: begin
                w_red = CH_FULL; w_green = w_z;     w_blue = w_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
            r_idx   <= '0;
        end else if (i_cfg_write) begin
            r_count <= w_cfg_count;
            r_idx   <= '0;
        end else if (i_cmd.mul) begin
            r_idx <= (w_idx_inc == w_m) ? '0 : w_idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hue <= i_in_data[KNOB_W-1:0];
            r_win <= i_in_data[2*KNOB_W-1:KNOB_W];
            r_sat <= i_in_data[3*KNOB_W-1:2*KNOB_W];
            r_int <= i_in_data[4*KNOB_W-1:3*KNOB_W];
        end
        if (i_cmd.mul) begin
            r_sum <= {7'b0, w_prod_hue} + w_prod_idx;
        end
        if (i_cmd.d1_load) begin
            r_rem  <= {7'b0, r_sum[SUM_W-1:14]};
            r_div  <= {7'b0, r_count};
            r_bits <= {r_sum[13:7], 8'b0};
            r_cnt  <= D1_LAST;
        end else if (i_cmd.d2_load) begin
            r_rem  <= w_t[19:3];
            r_div  <= w_m;
            r_bits <= {w_t[2:0], 12'b0};
            r_cnt  <= D2_LAST;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? IDX_W'(w_rr - {1'b0, r_div}) : w_rr[IDX_W-1:0];
            r_bits <= {r_bits[Q_W-2:0], 1'b0};
            r_q    <= {r_q[Q_W-2:0], w_ge};
            r_cnt  <= r_cnt - STEP_W'(1);
        end
        if (i_cmd.mix1) begin
            r_sr <= w_sat_ramp;
        end
        if (i_cmd.mix2) begin
            r_vx <= w_num255[26:12];
            r_vz <= w_vz;
            r_va <= w_va;
        end
        if (i_cmd.mix3) begin
            r_ex <= w_px[28:21];
            r_ez <= w_pz[28:21];
            r_ea <= w_pa[28:21];
        end
        if (i_cmd.out_load) begin
            r_out <= {w_al, w_blue, w_green, w_red};
        end
    end

    assign o_sts.div_last = (r_cnt == '0);
    assign o_out_data     = r_out;

endmodule

/* sv/hue_step_palette_hsv_to_rgb.sv */
// ----------------------------------------------------------------------------
// hue_step_palette_hsv_to_rgb
// Hue-step palette generator: HSV to RGBA with value fixed at one.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  hue, window, saturation, intensity
//  m_axis    out        m_axis_tvalid/m_axis_tready  red, green, blue, alpha
//  cfg       in         i_cfg_valid/o_cfg_ready      color count
//
//  One request in flight at a time: an idle state to accept, a product step, remainder
//  modulo the count, quotient over the palette period, then the mixing steps; the shared
//  restoring divider computes both the remainder and the quotient.
//  i_rst_n (synchronous, low): count 1, index 0; no clearing pass.
//  A result holds in the output register while the next request is taken;
//  that request then holds in its last mixing step until the register frees.
// ----------------------------------------------------------------------------
`include "hue_step_palette_hsv_to_rgb_defines.svh"

module hue_step_palette_hsv_to_rgb #(
    parameter int MAX_COUNT = 1023
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // hue_knob[6:0], window_knob[13:7], saturation_knob[20:14],
    // intensity_knob[27:21], zero[31:28]
    input  logic [hspal_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
    output logic [hspal_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hspal_pkg::COUNT_W-1:0]        i_cfg_data
);
    import hspal_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    hspal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hspal_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata[IN_W-1:0]),
        .i_cfg_write (w_cfg_write),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

    `HSP_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `HSP_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, !m_axis_tvalid || m_axis_tready)
    `HSP_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, w_cmd.out_load, m_axis_tvalid && s_axis_tready)
    `HSP_ASSERT_IMP(a_step_busy, i_clk, i_rst_n, w_cmd.div_step, !s_axis_tready)

endmodule
